### sv/first_fit_heap_allocator_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### sv/ffha_pkg.sv
// Types and constants shared by the first-fit heap allocator files.
package ffha_pkg;
  localparam int REQ_W = 21;
  localparam int OFF_W = 20;
  localparam int ST_W  = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } seg_t;
endpackage

### sv/ffha_req_if.sv
// Request channel of the allocator: operation, size and release offset.
interface ffha_req_if import ffha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] release_offset;

  modport source (output valid, op, request_bytes, release_offset, input ready);
  modport sink   (input valid, op, request_bytes, release_offset, output ready);
endinterface

### sv/ffha_rsp_if.sv
// Response channel of the allocator: status, offset and granted size.
interface ffha_rsp_if import ffha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] payload_offset;
  logic [REQ_W-1:0] granted_bytes;

  modport source (output valid, status, payload_offset, granted_bytes, input ready);
  modport sink   (input valid, status, payload_offset, granted_bytes, output ready);
endinterface

### sv/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/first_fit_heap_allocator.sv
// First-fit heap allocator: a sorted free-segment table and a block-size table in RAM.
//
// Usage: one request beat on req (op 0 allocate request_bytes, op 1 release the
// block at release_offset) gives exactly one response beat on rsp with status,
// payload_offset and granted_bytes. One request is worked on at a time; req.ready
// is high while the controller is idle, even if a response still waits on rsp.
// With N free segments in the table: a zero-size allocate goes straight to the
// response; an allocate scans the table in order until a segment fits, or
// reports no fit after all N entries, and when the whole segment is granted it
// shifts the tail entries down to close the gap. A release streams the table
// through, merging the released block with its neighbours; when the table is full
// the table is first scanned without writes to see whether any merge happens.
// The segment RAM has one read port, which every scan and shift walks one entry
// a cycle, apart from the re-read of the entry that the released block goes in
// front of; N is at most MAX_SEGMENTS.
// Reset (synchronous, rst high) sets the table to one segment covering the heap;
// entry zero is written during the reset cycle, so no clearing pass follows.
// The block-size RAM is not cleared; releasing a never-granted offset returns
// an undefined size. When rsp is stalled the response holds and a new request is
// still accepted; its result waits until the response register is free.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES      = 1048576,
  parameter int GRANULE_BYTES   = 8,
  parameter int HEADER_BYTES    = 24,
  parameter int MIN_SPLIT_BYTES = 56,
  parameter int MAX_SEGMENTS    = 256
) (
  input logic clk,
  input logic rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);
  localparam int GW    = $clog2(GRANULE_BYTES);
  localparam int SLOTS = HEAP_BYTES / GRANULE_BYTES;
  localparam int SW    = $clog2(SLOTS);
  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] HDR32     = 32'(HEADER_BYTES);
  localparam logic [31:0] MIN32     = 32'(MIN_SPLIT_BYTES);
  localparam logic [31:0] INIT_SIZE = 32'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [REQ_W:0] GMASK  = (REQ_W+1)'(GRANULE_BYTES - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_HDR     = 6'b000010,
    S_ASCAN   = 6'b000100,
    S_ASHIFT  = 6'b001000,
    S_RSTREAM = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next, rd_idx, rd_next, w, w_next;
  logic [IW-1:0] pidx, pidx_next;
  logic pend, pend_next, ins_done, ins_next, have_cur, hc_next;
  logic merged, merged_next, dry, dry_next, rsp_valid, rsp_valid_next;
  logic [31:0] need, need_next, hdr, hdr_next, fsize, fsize_next;
  seg_t cur, cur_next;
  status_t res_status, rs_next;
  logic [OFF_W-1:0] res_payload, rp_next;
  logic [REQ_W-1:0] res_granted, rg_next;
  status_t out_status;
  logic [OFF_W-1:0] out_payload;
  logic [REQ_W-1:0] out_granted;

  logic seg_we;
  logic [IW-1:0] seg_waddr, seg_raddr;
  seg_t seg_wdata, seg_rdata;
  logic hdr_we;
  logic [SW-1:0] hdr_waddr, hdr_raddr;
  logic [31:0] hdr_wdata, hdr_rdata;

  logic issue, p_en;
  seg_t e;
  logic [REQ_W:0] need_a;
  logic [31:0] rel32, left, pay;

  ffha_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  ffha_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hdr_ram (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = out_status;
  assign rsp.payload_offset = out_payload;
  assign rsp.granted_bytes  = out_granted;

  assign need_a = ((REQ_W+1)'(req.request_bytes) + GMASK) & ~GMASK;
  assign rel32  = 32'(req.release_offset);
  assign left   = seg_rdata.size - need;
  assign pay    = seg_rdata.start + HDR32;

  always_comb begin
    state_next = state;       count_next = count;     rd_next = rd_idx;
    pidx_next = pidx;         pend_next = pend;       need_next = need;
    hdr_next = hdr;           fsize_next = fsize;     ins_next = ins_done;
    hc_next = have_cur;       cur_next = cur;         w_next = w;
    merged_next = merged;     dry_next = dry;
    rs_next = res_status;     rp_next = res_payload;  rg_next = res_granted;
    rsp_valid_next = rsp_valid && !rsp.ready;
    seg_raddr = rd_idx[IW-1:0];
    seg_we = 1'b0;  seg_waddr = w[IW-1:0];  seg_wdata = cur;
    hdr_raddr = rel32[GW +: SW];
    hdr_we = 1'b0;  hdr_waddr = pay[GW +: SW];  hdr_wdata = need;
    issue = 1'b0;  p_en = 1'b0;
    e = '{start: hdr, size: fsize};

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_ALLOC) begin
            need_next = 32'(need_a);
            rd_next = '0;
            pend_next = 1'b0;
            if (req.request_bytes == '0) begin
              rs_next = ST_ZERO;  rp_next = '0;  rg_next = '0;
              state_next = S_FIN;
            end else begin
              state_next = S_ASCAN;
            end
          end else begin
            hdr_next = rel32 - HDR32;
            state_next = S_HDR;
          end
        end
      end
      S_HDR: begin
        fsize_next = hdr_rdata;
        dry_next = (count == CW'(MAX_SEGMENTS));
        rd_next = '0;  pend_next = 1'b0;  ins_next = 1'b0;
        hc_next = 1'b0;  w_next = '0;  merged_next = 1'b0;
        state_next = S_RSTREAM;
      end
      S_ASCAN: begin
        if (pend && (seg_rdata.size >= need)) begin
          rs_next = ST_OK;
          rp_next = pay[OFF_W-1:0];
          hdr_we = 1'b1;
          if (left >= MIN32 && left >= HDR32) begin
            seg_we = 1'b1;
            seg_waddr = pidx;
            seg_wdata = '{start: pay + need, size: left - HDR32};
            rg_next = need[REQ_W-1:0];
            state_next = S_FIN;
          end else begin
            // Whole segment granted: close the gap by shifting the tail down.
            hdr_wdata = seg_rdata.size;
            rg_next = seg_rdata.size[REQ_W-1:0];
            rd_next = CW'(pidx) + CW'(1);
            pend_next = 1'b0;
            state_next = S_ASHIFT;
          end
        end else if (!pend && rd_idx >= count) begin
          rs_next = ST_NO_FIT;  rp_next = '0;  rg_next = '0;
          state_next = S_FIN;
        end else begin
          issue = 1'b1;
        end
      end
      S_ASHIFT: begin
        if (pend) begin
          seg_we = 1'b1;
          seg_waddr = pidx - IW'(1);
          seg_wdata = seg_rdata;
        end
        if (!pend && rd_idx >= count) begin
          count_next = count - CW'(1);
          state_next = S_FIN;
        end else begin
          issue = 1'b1;
        end
      end
      S_RSTREAM: begin
        if (pend && !ins_done && seg_rdata.start > hdr) begin
          // The released block goes in front of this entry; read it again.
          p_en = 1'b1;
          ins_next = 1'b1;
          rd_next = CW'(pidx);
          pend_next = 1'b0;
        end else if (pend) begin
          p_en = 1'b1;
          e = seg_rdata;
          issue = 1'b1;
        end else if (rd_idx < count) begin
          issue = 1'b1;
        end else if (!ins_done) begin
          p_en = 1'b1;
          ins_next = 1'b1;
        end else if (dry) begin
          if (merged) begin
            dry_next = 1'b0;  rd_next = '0;  pend_next = 1'b0;  ins_next = 1'b0;
            hc_next = 1'b0;  w_next = '0;  merged_next = 1'b0;
          end else begin
            rs_next = ST_FULL;  rp_next = '0;  rg_next = '0;
            state_next = S_FIN;
          end
        end else begin
          seg_we = 1'b1;
          count_next = w + CW'(1);
          rs_next = ST_OK;  rp_next = '0;  rg_next = '0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (issue) begin
      pend_next = (rd_idx < count);
      pidx_next = rd_idx[IW-1:0];
      if (rd_idx < count) begin
        rd_next = rd_idx + CW'(1);
      end
    end

    // Merge the incoming entry into the held one, or flush the held one.
    if (p_en) begin
      if (!have_cur) begin
        cur_next = e;
        hc_next = 1'b1;
      end else if (cur.start + HDR32 + cur.size == e.start) begin
        cur_next.size = cur.size + HDR32 + e.size;
        merged_next = 1'b1;
      end else begin
        seg_we = !dry;
        seg_waddr = w[IW-1:0];
        seg_wdata = cur;
        w_next = w + CW'(1);
        cur_next = e;
      end
    end

    if (rst) begin
      seg_we = 1'b1;
      seg_waddr = '0;
      seg_wdata = '{start: 32'd0, size: INIT_SIZE};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(1);
      rsp_valid <= 1'b0;
      pend <= 1'b0;
      ins_done <= 1'b0;
      have_cur <= 1'b0;
      merged <= 1'b0;
      dry <= 1'b0;
      rd_idx <= '0;
      w <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      rsp_valid <= rsp_valid_next;
      pend <= pend_next;
      ins_done <= ins_next;
      have_cur <= hc_next;
      merged <= merged_next;
      dry <= dry_next;
      rd_idx <= rd_next;
      w <= w_next;
    end
  end

  always_ff @(posedge clk) begin
    pidx <= pidx_next;
    need <= need_next;
    hdr <= hdr_next;
    fsize <= fsize_next;
    cur <= cur_next;
    res_status <= rs_next;
    res_payload <= rp_next;
    res_granted <= rg_next;
    // The response register only takes a new result once the previous beat has left.
    if (state == S_FIN && (!rsp_valid || rsp.ready)) begin
      out_status <= res_status;
      out_payload <= res_payload;
      out_granted <= res_granted;
    end
  end
endmodule

### sv/ffha_checker.sv
// Port-level checks of the allocator, bound to the top level.
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker import ffha_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  status,
  input logic [OFF_W-1:0] payload_offset,
  input logic [REQ_W-1:0] granted_bytes
);
  // Requests are served one at a time, so an accepted beat drops ready.
  `FFHA_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  `FFHA_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(payload_offset) && $stable(granted_bytes))

  // Any failed request reports a zero offset and a zero size.
  `FFHA_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && status != ST_OK, payload_offset == '0 && granted_bytes == '0)
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(req.valid),
  .in_ready(req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .status(rsp.status),
  .payload_offset(rsp.payload_offset),
  .granted_bytes(rsp.granted_bytes)
);
